[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is low
`define NDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property, also during reset
`define NDG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/ndg_pkg.sv]
// Types and constants of the normal to depth gradient unit
package ndg_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Divider widths: dividend and quotient magnitude, divisor magnitude
  localparam int DIV_QW = 64;
  localparam int DIV_DW = 54;
  localparam int DIV_STAGES = DIV_QW;

  // Configuration register indices
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_FOCAL_X  = 2'd2;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd3;

  localparam logic [15:0] CENTER_X_RST = 16'd17280;
  localparam logic [15:0] CENTER_Y_RST = 16'd30720;
  localparam logic signed [25:0] FOCAL_X_RST = 26'sd1105920;
  localparam logic signed [25:0] FOCAL_Y_RST = -26'sd2058667;

  localparam logic signed [31:0] SLOPE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SLOPE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [11:0]        pixel_col;
    logic [11:0]        pixel_row;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        depth_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic               denominator_zero;
    logic               saturated;
  } out_t;

endpackage

[sv/ndg_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage
module ndg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ndg_pkg::DIV_QW-1:0]  dividend,
  input  logic [ndg_pkg::DIV_DW-1:0]  divisor,
  output logic                        out_valid,
  output logic [ndg_pkg::DIV_QW-1:0]  quotient
);

  localparam int NS = ndg_pkg::DIV_STAGES;
  localparam int QW = ndg_pkg::DIV_QW;
  localparam int DW = ndg_pkg::DIV_DW;

  logic [DW-1:0] rem_r [0:NS-1];
  logic [QW-1:0] nq_r  [0:NS-1];
  logic [DW-1:0] d_r   [0:NS-1];
  logic          dz_r  [0:NS-1];
  logic          v_r   [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] prev_rem;
    logic [QW-1:0] prev_nq;
    logic [DW-1:0] prev_d;
    logic          prev_dz;
    logic          prev_v;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] nq_nxt;

    // stage inputs: ports for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign prev_rem = '0;
      assign prev_nq  = dividend;
      assign prev_d   = divisor;
      assign prev_dz  = (divisor == '0);
      assign prev_v   = in_valid;
    end else begin : g_next
      assign prev_rem = rem_r[k-1];
      assign prev_nq  = nq_r[k-1];
      assign prev_d   = d_r[k-1];
      assign prev_dz  = dz_r[k-1];
      assign prev_v   = v_r[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    always_comb begin
      trial   = {prev_rem, prev_nq[QW-1]};
      ge      = (trial >= {1'b0, prev_d});
      rem_nxt = ge ? DW'(trial - {1'b0, prev_d}) : trial[DW-1:0];
      nq_nxt  = {prev_nq[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        nq_r[k]  <= nq_nxt;
        d_r[k]   <= prev_d;
        dz_r[k]  <= prev_dz;
      end
    end
  end

  // zero divisor gives zero
  assign out_valid = v_r[NS-1];
  assign quotient  = dz_r[NS-1] ? '0 : nq_r[NS-1];

endmodule

[sv/normal_to_depth_gradient_unit.sv]
// Top level of the normal to depth gradient unit
//
//  port group | dir | handshake        | payload
//  in_        | in  | in_valid/ready   | ndg_pkg::in_t  (pixel, normal, depth)
//  out_       | out | out_valid/ready  | ndg_pkg::out_t (slopes and flags)
//  cfg_       | in  | cfg_we           | cfg_addr, cfg_wdata (26 bit)
//
// One pixel a cycle unless the pipe is stalled; the pipe holds two 64-stage divider banks.
// First bank divides by the focal lengths, second by the denominator.
// Reset is synchronous; it clears valid bits and restores the register defaults.
// A stall freezes the whole pipe: in_ready is low while a result waits untaken.
`include "assert_macros.svh"

module normal_to_depth_gradient_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ndg_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ndg_pkg::out_t       out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [25:0]         cfg_wdata
);

  localparam int NS = ndg_pkg::DIV_STAGES;
  localparam int QW = ndg_pkg::DIV_QW;
  localparam int DW = ndg_pkg::DIV_DW;

  typedef struct packed {
    logic signed [15:0] nz;
    logic               sx;
    logic               sy;
    logic               snx;
    logic               sny;
  } side1_t;

  typedef struct packed {
    logic sx;
    logic sy;
    logic zero;
  } side2_t;

  // configuration registers
  logic [15:0]        center_x_r, center_y_r;
  logic signed [25:0] focal_x_r, focal_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= ndg_pkg::CENTER_X_RST;
      center_y_r <= ndg_pkg::CENTER_Y_RST;
      focal_x_r  <= ndg_pkg::FOCAL_X_RST;
      focal_y_r  <= ndg_pkg::FOCAL_Y_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        ndg_pkg::REG_CENTER_X: center_x_r <= cfg_wdata[15:0];
        ndg_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata[15:0];
        ndg_pkg::REG_FOCAL_X:  focal_x_r  <= $signed(cfg_wdata);
        ndg_pkg::REG_FOCAL_Y:  focal_y_r  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless a result waits and out_ready is low
  logic en;
  logic out_valid_r;
  ndg_pkg::out_t out_data_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: offsets from the optical centre (12-bit coordinates never exceed the limit)
  logic               s1_v_r;
  logic signed [17:0] s1_dx_r, s1_dy_r;
  logic signed [15:0] s1_nx_r, s1_ny_r, s1_nz_r;
  logic [15:0]        s1_z_r;
  logic signed [17:0] dx_nxt, dy_nxt;

  assign dx_nxt = $signed({2'b00, in_data.pixel_col, 4'b0000}) - $signed({2'b00, center_x_r});
  assign dy_nxt = $signed({2'b00, in_data.pixel_row, 4'b0000}) - $signed({2'b00, center_y_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= dx_nxt;
      s1_dy_r <= dy_nxt;
      s1_nx_r <= in_data.normal_x;
      s1_ny_r <= in_data.normal_y;
      s1_nz_r <= in_data.normal_z;
      s1_z_r  <= in_data.depth_value;
    end
  end

  // stage 2: products
  logic               s2_v_r;
  logic signed [33:0] s2_px_r, s2_py_r;
  logic signed [32:0] s2_mx_r, s2_my_r;
  logic signed [15:0] s2_nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px_r <= 34'(s1_nx_r) * 34'(s1_dx_r);
      s2_py_r <= 34'(s1_ny_r) * 34'(s1_dy_r);
      s2_mx_r <= 33'(s1_nx_r) * $signed({17'b0, s1_z_r});
      s2_my_r <= 33'(s1_ny_r) * $signed({17'b0, s1_z_r});
      s2_nz_r <= s1_nz_r;
    end
  end

  // stage 3: magnitudes and signs for the focal-length divisions
  logic          s3_v_r;
  logic [QW-1:0] s3_ntx_r, s3_nty_r, s3_nnx_r, s3_nny_r;
  logic [DW-1:0] s3_fx_r, s3_fy_r;
  side1_t        s3_side_r;
  logic [33:0]   pxm, pym;
  logic [32:0]   mxm, mym;
  logic [25:0]   fxm, fym;

  always_comb begin
    pxm = s2_px_r[33] ? 34'(-s2_px_r) : 34'(s2_px_r);
    pym = s2_py_r[33] ? 34'(-s2_py_r) : 34'(s2_py_r);
    mxm = s2_mx_r[32] ? 33'(-s2_mx_r) : 33'(s2_mx_r);
    mym = s2_my_r[32] ? 33'(-s2_my_r) : 33'(s2_my_r);
    fxm = focal_x_r[25] ? 26'(-focal_x_r) : 26'(focal_x_r);
    fym = focal_y_r[25] ? 26'(-focal_y_r) : 26'(focal_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ntx_r      <= QW'({pxm, 20'b0});
      s3_nty_r      <= QW'({pym, 20'b0});
      s3_nnx_r      <= QW'({mxm, 16'b0});
      s3_nny_r      <= QW'({mym, 16'b0});
      s3_fx_r       <= DW'(fxm);
      s3_fy_r       <= DW'(fym);
      s3_side_r.nz  <= s2_nz_r;
      s3_side_r.sx  <= s2_px_r[33] ^ focal_x_r[25];
      s3_side_r.sy  <= s2_py_r[33] ^ focal_y_r[25];
      s3_side_r.snx <= s2_mx_r[32] ^ focal_x_r[25];
      s3_side_r.sny <= s2_my_r[32] ^ focal_y_r[25];
    end
  end

  // first divider bank
  logic          b1_v, b1_v1, b1_v2, b1_v3;
  logic [QW-1:0] q_tx, q_ty, q_nx, q_ny;

  ndg_div u_div_tx (.clk, .rst_n, .en, .in_valid(s3_v_r), .dividend(s3_ntx_r),
                    .divisor(s3_fx_r), .out_valid(b1_v), .quotient(q_tx));
  ndg_div u_div_ty (.clk, .rst_n, .en, .in_valid(s3_v_r), .dividend(s3_nty_r),
                    .divisor(s3_fy_r), .out_valid(b1_v1), .quotient(q_ty));
  ndg_div u_div_nx (.clk, .rst_n, .en, .in_valid(s3_v_r), .dividend(s3_nnx_r),
                    .divisor(s3_fx_r), .out_valid(b1_v2), .quotient(q_nx));
  ndg_div u_div_ny (.clk, .rst_n, .en, .in_valid(s3_v_r), .dividend(s3_nny_r),
                    .divisor(s3_fy_r), .out_valid(b1_v3), .quotient(q_ny));

  side1_t side1_r [0:NS-1];
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= s3_side_r;
      for (int k = 1; k < NS; k++) begin
        side1_r[k] <= side1_r[k-1];
      end
    end
  end

  // stage 4: signed terms, denominator and numerators
  logic               s4_v_r;
  logic signed [DW-1:0] s4_den_r;
  logic signed [QW-1:0] s4_numx_r, s4_numy_r;
  logic signed [QW-1:0] tx_s, ty_s, den_full;
  side1_t             sd1;

  always_comb begin
    sd1      = side1_r[NS-1];
    tx_s     = sd1.sx ? $signed(-q_tx) : $signed(q_tx);
    ty_s     = sd1.sy ? $signed(-q_ty) : $signed(q_ty);
    den_full = (QW'(sd1.nz) <<< 16) - tx_s - ty_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_den_r  <= den_full[DW-1:0];
      s4_numx_r <= sd1.snx ? $signed(-q_nx) : $signed(q_nx);
      s4_numy_r <= sd1.sny ? $signed(-q_ny) : $signed(q_ny);
    end
  end

  // stage 5: magnitudes, signs and zero flag for the slope divisions
  logic          s5_v_r;
  logic [QW-1:0] s5_nx_r, s5_ny_r;
  logic [DW-1:0] s5_den_r;
  side2_t        s5_side_r;
  logic [QW-1:0] numxm, numym;

  always_comb begin
    numxm = s4_numx_r[QW-1] ? QW'(-s4_numx_r) : QW'(s4_numx_r);
    numym = s4_numy_r[QW-1] ? QW'(-s4_numy_r) : QW'(s4_numy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_nx_r        <= {numxm[QW-17:0], 16'b0};
      s5_ny_r        <= {numym[QW-17:0], 16'b0};
      s5_den_r       <= s4_den_r[DW-1] ? DW'(-s4_den_r) : DW'(s4_den_r);
      s5_side_r.sx   <= s4_numx_r[QW-1] ^ s4_den_r[DW-1];
      s5_side_r.sy   <= s4_numy_r[QW-1] ^ s4_den_r[DW-1];
      s5_side_r.zero <= (s4_den_r == '0);
    end
  end

  // second divider bank
  logic          b2_v, b2_v1;
  logic [QW-1:0] q_sx, q_sy;

  ndg_div u_div_sx (.clk, .rst_n, .en, .in_valid(s5_v_r), .dividend(s5_nx_r),
                    .divisor(s5_den_r), .out_valid(b2_v), .quotient(q_sx));
  ndg_div u_div_sy (.clk, .rst_n, .en, .in_valid(s5_v_r), .dividend(s5_ny_r),
                    .divisor(s5_den_r), .out_valid(b2_v1), .quotient(q_sy));

  side2_t side2_r [0:NS-1];
  always_ff @(posedge clk) begin
    if (en) begin
      side2_r[0] <= s5_side_r;
      for (int k = 1; k < NS; k++) begin
        side2_r[k] <= side2_r[k-1];
      end
    end
  end

  // output stage: sign, clip and flags
  side2_t        sd2;
  logic          satx, saty;
  logic [31:0]   slx, sly;
  ndg_pkg::out_t out_nxt;

  always_comb begin
    sd2  = side2_r[NS-1];
    satx = sd2.sx ? (q_sx > QW'(64'h8000_0000)) : (q_sx > QW'(64'h7FFF_FFFF));
    saty = sd2.sy ? (q_sy > QW'(64'h8000_0000)) : (q_sy > QW'(64'h7FFF_FFFF));
    if (satx) begin
      slx = sd2.sx ? ndg_pkg::SLOPE_MIN : ndg_pkg::SLOPE_MAX;
    end else begin
      slx = sd2.sx ? 32'(-q_sx[31:0]) : q_sx[31:0];
    end
    if (saty) begin
      sly = sd2.sy ? ndg_pkg::SLOPE_MIN : ndg_pkg::SLOPE_MAX;
    end else begin
      sly = sd2.sy ? 32'(-q_sy[31:0]) : q_sy[31:0];
    end
    out_nxt.denominator_zero = sd2.zero;
    out_nxt.slope_x   = sd2.zero ? '0 : $signed(slx);
    out_nxt.slope_y   = sd2.zero ? '0 : $signed(sly);
    out_nxt.saturated = !sd2.zero && (satx || saty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `NDG_ASSERT(a_zero_den, (out_valid_r && out_data_r.denominator_zero) |-> (out_data_r.slope_x == 0 && out_data_r.slope_y == 0 && !out_data_r.saturated), "zero denominator beat with nonzero slopes")
  `NDG_ASSERT(a_sat_ext, (out_valid_r && out_data_r.saturated) |-> (out_data_r.slope_x == ndg_pkg::SLOPE_MAX || out_data_r.slope_x == ndg_pkg::SLOPE_MIN || out_data_r.slope_y == ndg_pkg::SLOPE_MAX || out_data_r.slope_y == ndg_pkg::SLOPE_MIN), "saturated beat without a clipped slope")
  `NDG_ASSERT(a_bank_align, (b1_v == b1_v1) && (b1_v == b1_v2) && (b1_v == b1_v3) && (b2_v == b2_v1), "divider banks out of step")
  `NDG_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid_r, "result valid straight after reset")

endmodule
